// ===== sv/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and widths for the segment/plane clipper.
// ----------------------------------------------------------------------------
package spc_pkg;

   // field widths
   localparam int COORD_W     = 32;
   localparam int NORMAL_W    = 16;
   localparam int NORMAL_FRAC = 14;
   localparam int PROD_W      = NORMAL_W + COORD_W;          // n * p
   localparam int DIST_W      = PROD_W + 3;                  // signed distance
   localparam int MAG_W       = DIST_W + 1;                  // |d1 - d2|
   localparam int DELTA_W     = COORD_W + 1;                 // end - start
   localparam int Q_W         = COORD_W;                     // |quotient| < 2^32
   localparam int REM_W       = MAG_W + Q_W;                 // divider remainder
   localparam int D1_LO_W     = 25;                          // |d1| split
   localparam int D1_HI_W     = DIST_W - D1_LO_W;
   localparam int DL_LO_W     = 16;                          // |delta| split
   localparam int DL_HI_W     = Q_W - DL_LO_W;
   localparam int PP_W        = D1_HI_W + DL_HI_W;
   localparam int DIV_STEPS   = Q_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   typedef enum logic [1:0] {
      REG_NORMAL_X   = 2'd0,
      REG_NORMAL_Y   = 2'd1,
      REG_NORMAL_Z   = 2'd2,
      REG_PLANE_DIST = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic                      kept;
      logic signed [COORD_W-1:0] out_start_x;
      logic signed [COORD_W-1:0] out_start_y;
      logic signed [COORD_W-1:0] out_start_z;
      logic signed [COORD_W-1:0] out_end_x;
      logic signed [COORD_W-1:0] out_end_y;
      logic signed [COORD_W-1:0] out_end_z;
   } rsp_type;

   typedef struct packed {
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
      logic signed [COORD_W-1:0]  plane_dist;
   } cfg_type;

   // per-segment context carried down the pipe
   typedef struct packed {
      logic [2:0][COORD_W-1:0] a;
      logic [2:0][COORD_W-1:0] b;
      logic                    kept;
      logic                    clip;
      logic                    sel_start;
      logic [2:0]              qneg;
   } ctx_type;

   // divider stage payload
   typedef struct packed {
      ctx_type               ctx;
      logic [MAG_W-1:0]      den;
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][Q_W-1:0]   quo;
   } div_type;

endpackage

// ===== sv/spc_csr.sv =====
// ----------------------------------------------------------------------------
// spc_csr
// APB register file holding the plane normal and distance.
// ----------------------------------------------------------------------------
module spc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [spc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output spc_pkg::cfg_type               cfg
);
   import spc_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_x   <= '0;
         cfg_ff.normal_y   <= '0;
         cfg_ff.normal_z   <= NORMAL_W'(16384);
         cfg_ff.plane_dist <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_NORMAL_X:   cfg_ff.normal_x   <= pwdata[NORMAL_W-1:0];
            REG_NORMAL_Y:   cfg_ff.normal_y   <= pwdata[NORMAL_W-1:0];
            REG_NORMAL_Z:   cfg_ff.normal_z   <= pwdata[NORMAL_W-1:0];
            REG_PLANE_DIST: cfg_ff.plane_dist <= pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_NORMAL_X:   prdata = CSR_DATA_W'(cfg_ff.normal_x);
         REG_NORMAL_Y:   prdata = CSR_DATA_W'(cfg_ff.normal_y);
         REG_NORMAL_Z:   prdata = CSR_DATA_W'(cfg_ff.normal_z);
         REG_PLANE_DIST: prdata = CSR_DATA_W'(cfg_ff.plane_dist);
         default:        prdata = '0;
      endcase
   end

endmodule

// ===== sv/spc_front.sv =====
// ----------------------------------------------------------------------------
// spc_front
// Five-stage front end: plane distances, classification and the exact
// numerator |d1| * |end - start| for each axis.
// ----------------------------------------------------------------------------
module spc_front (
   input  logic             clock,
   input  logic             reset,
   input  spc_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  spc_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output spc_pkg::div_type out_data
);
   import spc_pkg::*;

   logic [4:0] v_ff;
   logic [5:0] rdy;

   // stage ready chain: a stage loads when empty or when it drains
   always_comb begin
      rdy[5] = out_ready;
      for (int k = 4; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < 5; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---- stage 1: normal products
   logic [2:0][COORD_W-1:0]   a1_in, b1_in;
   logic signed [NORMAL_W-1:0] nrm [3];
   logic signed [PROD_W-1:0]   pa1_in [3];
   logic signed [PROD_W-1:0]   pb1_in [3];
   logic signed [DIST_W-1:0]   off1_in;
   logic [2:0][COORD_W-1:0]   a1_ff, b1_ff;
   logic signed [PROD_W-1:0]   pa1_ff [3];
   logic signed [PROD_W-1:0]   pb1_ff [3];
   logic signed [DIST_W-1:0]   off1_ff;

   always_comb begin
      a1_in   = {in_data.start_z, in_data.start_y, in_data.start_x};
      b1_in   = {in_data.end_z, in_data.end_y, in_data.end_x};
      nrm[0]  = cfg.normal_x;
      nrm[1]  = cfg.normal_y;
      nrm[2]  = cfg.normal_z;
      for (int i = 0; i < 3; i++) begin
         pa1_in[i] = nrm[i] * $signed(a1_in[i]);
         pb1_in[i] = nrm[i] * $signed(b1_in[i]);
      end
      off1_in = DIST_W'(cfg.plane_dist) <<< NORMAL_FRAC;
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         pa1_ff  <= pa1_in;
         pb1_ff  <= pb1_in;
         off1_ff <= off1_in;
      end
   end

   // ---- stage 2: signed distances
   logic signed [DIST_W-1:0] d1_in, d2_in, d1_ff, d2_ff;
   logic [2:0][COORD_W-1:0]  a2_ff, b2_ff;

   always_comb begin
      d1_in = DIST_W'(pa1_ff[0]) + DIST_W'(pa1_ff[1]) + DIST_W'(pa1_ff[2]) - off1_ff;
      d2_in = DIST_W'(pb1_ff[0]) + DIST_W'(pb1_ff[1]) + DIST_W'(pb1_ff[2]) - off1_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && v_ff[0]) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   // ---- stage 3: classify, magnitudes
   ctx_type                ctx3_in, ctx3_ff;
   logic [MAG_W-1:0]       den3_in, den3_ff;
   logic [DIST_W-1:0]      md13_in, md13_ff;
   logic [2:0][Q_W-1:0]    mdl3_in, mdl3_ff;
   logic signed [MAG_W-1:0]   den_s;
   logic signed [DELTA_W-1:0] delta;
   logic                   n1, n2, p1, p2;

   always_comb begin
      n1    = d1_ff[DIST_W-1];
      n2    = d2_ff[DIST_W-1];
      p1    = !n1 && (d1_ff != '0);
      p2    = !n2 && (d2_ff != '0);
      den_s = MAG_W'(d1_ff) - MAG_W'(d2_ff);
      den3_in = den_s[MAG_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
      md13_in = n1 ? DIST_W'(-d1_ff) : DIST_W'(d1_ff);
      ctx3_in.a         = a2_ff;
      ctx3_in.b         = b2_ff;
      ctx3_in.kept      = n1 || n2;
      ctx3_in.clip      = (n1 || n2) && (p1 || p2);
      ctx3_in.sel_start = p1;
      for (int i = 0; i < 3; i++) begin
         delta = DELTA_W'($signed(b2_ff[i])) - DELTA_W'($signed(a2_ff[i]));
         mdl3_in[i] = delta[DELTA_W-1] ? Q_W'(-delta) : Q_W'(delta);
         ctx3_in.qneg[i] = n1 ^ delta[DELTA_W-1] ^ den_s[MAG_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2] && v_ff[1]) begin
         ctx3_ff <= ctx3_in;
         den3_ff <= den3_in;
         md13_ff <= md13_in;
         mdl3_ff <= mdl3_in;
      end
   end

   // ---- stage 4: partial products of |d1| * |delta|
   ctx_type               ctx4_ff;
   logic [MAG_W-1:0]      den4_ff;
   logic [2:0][PP_W-1:0]  pll_in, plh_in, phl_in, phh_in;
   logic [2:0][PP_W-1:0]  pll_ff, plh_ff, phl_ff, phh_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pll_in[i] = PP_W'(md13_ff[D1_LO_W-1:0]) * PP_W'(mdl3_ff[i][DL_LO_W-1:0]);
         plh_in[i] = PP_W'(md13_ff[D1_LO_W-1:0]) * PP_W'(mdl3_ff[i][Q_W-1:DL_LO_W]);
         phl_in[i] = PP_W'(md13_ff[DIST_W-1:D1_LO_W]) * PP_W'(mdl3_ff[i][DL_LO_W-1:0]);
         phh_in[i] = PP_W'(md13_ff[DIST_W-1:D1_LO_W]) * PP_W'(mdl3_ff[i][Q_W-1:DL_LO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3] && v_ff[2]) begin
         ctx4_ff <= ctx3_ff;
         den4_ff <= den3_ff;
         pll_ff  <= pll_in;
         plh_ff  <= plh_in;
         phl_ff  <= phl_in;
         phh_ff  <= phh_in;
      end
   end

   // ---- stage 5: sum into the numerator, seed the divider
   div_type out_in, out_ff;

   always_comb begin
      out_in.ctx = ctx4_ff;
      out_in.den = den4_ff;
      for (int i = 0; i < 3; i++) begin
         out_in.rem[i] = REM_W'(pll_ff[i])
                       + (REM_W'(plh_ff[i]) << DL_LO_W)
                       + (REM_W'(phl_ff[i]) << D1_LO_W)
                       + (REM_W'(phh_ff[i]) << (D1_LO_W + DL_LO_W));
         out_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4] && v_ff[3]) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule

// ===== sv/spc_div_step.sv =====
// ----------------------------------------------------------------------------
// spc_div_step
// One registered restoring-division step: one quotient bit for each axis.
// ----------------------------------------------------------------------------
module spc_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  spc_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output spc_pkg::div_type out_data
);
   import spc_pkg::*;

   logic       v_ff;
   div_type    nxt_in, data_ff;
   logic [REM_W-1:0] dsh;
   logic [REM_W-1:0] rem;
   logic             qbit;

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = data_ff;

   // compare against den aligned to the top quotient bit, then shift left
   always_comb begin
      dsh    = REM_W'(in_data.den) << (Q_W - 1);
      nxt_in = in_data;
      for (int i = 0; i < 3; i++) begin
         qbit = in_data.rem[i] >= dsh;
         rem  = qbit ? (in_data.rem[i] - dsh) : in_data.rem[i];
         nxt_in.rem[i] = rem << 1;
         nxt_in.quo[i] = {in_data.quo[i][Q_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= nxt_in;
      end
   end

endmodule

// ===== sv/spc_back.sv =====
// ----------------------------------------------------------------------------
// spc_back
// Applies the quotient sign, moves the outside endpoint onto the plane and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module spc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  spc_pkg::div_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spc_pkg::rsp_type rsp_payload
);
   import spc_pkg::*;

   logic                    v_ff;
   rsp_type                 rsp_in, rsp_ff;
   logic [2:0][COORD_W-1:0] pt, sa, sb;
   logic [COORD_W-1:0]      sq;

   assign in_ready    = !v_ff || !rsp_stall;
   assign rsp_valid   = v_ff;
   assign rsp_payload = rsp_ff;

   // clipped point per axis
   always_comb begin
      sa = in_data.ctx.a;
      sb = in_data.ctx.b;
      for (int i = 0; i < 3; i++) begin
         sq    = in_data.ctx.qneg[i] ? (~in_data.quo[i] + 1'b1) : in_data.quo[i];
         pt[i] = in_data.ctx.a[i] + sq;
         if (in_data.ctx.clip) begin
            if (in_data.ctx.sel_start) begin
               sa[i] = pt[i];
            end else begin
               sb[i] = pt[i];
            end
         end
      end
      rsp_in.kept        = in_data.ctx.kept;
      rsp_in.out_start_x = sa[0];
      rsp_in.out_start_y = sa[1];
      rsp_in.out_start_z = sa[2];
      rsp_in.out_end_x   = sb[0];
      rsp_in.out_end_y   = sb[1];
      rsp_in.out_end_z   = sb[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sv/segment_plane_clip.sv =====
// ----------------------------------------------------------------------------
// segment_plane_clip
// Clips a 3D segment against the plane n.P = D held in the registers.
// ----------------------------------------------------------------------------
// Fully pipelined: one segment per cycle as long as no result-side stall backs
// up the pipe. A segment passes 5 front-end stages for distances and the exact
// numerator, 32 divider stages giving one quotient bit each and 1 output register. Every
// stage holds its own valid bit and loads whenever it is empty or drains, so
// a stall on the result side only backs up as far as the pipe is full.
// Registers: 0x0 normal_x, 0x4 normal_y, 0x8 normal_z (Q1.14), 0xC plane_dist
// (Q16.16); write them only while no segment is in flight.
module segment_plane_clip (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [spc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  spc_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output spc_pkg::rsp_type               rsp_payload
);
   import spc_pkg::*;

   cfg_type cfg;
   logic    front_ready;

   div_type div_data  [DIV_STEPS+1];
   logic    div_valid [DIV_STEPS+1];
   logic    div_ready [DIV_STEPS+1];

   spc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = !front_ready;

   spc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_payload),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // divider chain
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      spc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   spc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (div_valid[DIV_STEPS]),
      .in_ready    (div_ready[DIV_STEPS]),
      .in_data     (div_data[DIV_STEPS]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/segment_plane_clip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_plane_clip_checker
// Watches both channels and the register port of the clipper, predicts each
// clipped segment with exact wide arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
module segment_plane_clip_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [spc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spc_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  spc_pkg::req_type               req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  spc_pkg::rsp_type               rsp_payload,
   output int                             fail_count,
   output int                             pending_count
);
   import spc_pkg::*;

   logic signed [15:0] plane_nx, plane_ny, plane_nz;
   logic signed [31:0] plane_d;
   rsp_type            clip_queue[$];

   // signed distance of a point from the plane, 30 fraction bits
   function automatic logic signed [127:0] point_distance(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
      logic signed [127:0] acc;
      acc = 128'(plane_nx) * 128'(px) + 128'(plane_ny) * 128'(py)
          + 128'(plane_nz) * 128'(pz) - (128'(plane_d) <<< NORMAL_FRAC);
      return acc;
   endfunction

   function automatic rsp_type clip_segment(input req_type s);
      rsp_type             r;
      logic signed [127:0] d1, d2, den, q, num;
      logic signed [31:0]  a[3], b[3], moved[3];
      a = '{s.start_x, s.start_y, s.start_z};
      b = '{s.end_x, s.end_y, s.end_z};
      d1 = point_distance(a[0], a[1], a[2]);
      d2 = point_distance(b[0], b[1], b[2]);
      r = '{kept: 1'b1, out_start_x: a[0], out_start_y: a[1], out_start_z: a[2],
            out_end_x: b[0], out_end_y: b[1], out_end_z: b[2]};
      if (d1 >= 0 && d2 >= 0) begin
         r.kept = 1'b0;
      end else if (!(d1 <= 0 && d2 <= 0)) begin
         den = d1 - d2;
         for (int i = 0; i < 3; i++) begin
            num = d1 * (128'(b[i]) - 128'(a[i]));
            q = num / den;   // SV signed division truncates toward zero
            moved[i] = a[i] + q[31:0];
         end
         if (d1 > 0) begin
            r.out_start_x = moved[0]; r.out_start_y = moved[1]; r.out_start_z = moved[2];
         end else begin
            r.out_end_x = moved[0]; r.out_end_y = moved[1]; r.out_end_z = moved[2];
         end
      end
      return r;
   endfunction

   assign pending_count = clip_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         plane_nx <= 16'sd0;
         plane_ny <= 16'sd0;
         plane_nz <= 16'sd16384;
         plane_d  <= 32'sd0;
         fail_count <= 0;
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[3:2]))
               REG_NORMAL_X:   plane_nx <= pwdata[15:0];
               REG_NORMAL_Y:   plane_ny <= pwdata[15:0];
               REG_NORMAL_Z:   plane_nz <= pwdata[15:0];
               REG_PLANE_DIST: plane_d  <= pwdata;
            endcase
         end
         // segment transfer in
         if (req_valid && !req_stall)
            clip_queue.push_back(clip_segment(req_payload));
         // result transfer out
         if (rsp_valid && !rsp_stall) begin
            if (clip_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = clip_queue.pop_front();
               if (want.kept !== rsp_payload.kept ||
                   want.out_start_x !== rsp_payload.out_start_x ||
                   want.out_start_y !== rsp_payload.out_start_y ||
                   want.out_start_z !== rsp_payload.out_start_z ||
                   want.out_end_x !== rsp_payload.out_end_x ||
                   want.out_end_y !== rsp_payload.out_end_y ||
                   want.out_end_z !== rsp_payload.out_end_z) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want,
                           rsp_payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== dv/segment_plane_clip_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_plane_clip_test
// Drives segments and plane settings into the clipper under random idling
// and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module segment_plane_clip_test;
   import spc_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid = 1'b0, req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid, rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   int                    fail_count, pending_count;
   bit                    hold_off = 1'b0;

   always #5 clock = ~clock;

   segment_plane_clip uut (.*);
   segment_plane_clip_checker chk (.*);

   // coordinate: mostly small, sometimes extreme or fully random
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return $urandom();
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // wait until the pipe has drained
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_plane(input logic [15:0] nx, input logic [15:0] ny,
                            input logic [15:0] nz, input logic [31:0] d);
      drain();
      csr_write(REG_NORMAL_X, {16'h0, nx});
      csr_write(REG_NORMAL_Y, {16'h0, ny});
      csr_write(REG_NORMAL_Z, {16'h0, nz});
      csr_write(REG_PLANE_DIST, d);
   endtask

   // offer one segment and hold it until transferred
   task automatic send(input req_type s);
      req_valid <= 1'b1;
      req_payload <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic random_burst(input int count);
      req_type s;
      int      burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         s = '{rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord()};
         send(s);
         if (burst == 0) begin
            if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 6));
            burst = $urandom_range(1, 20);
         end else begin
            burst--;
         end
      end
      idle(1);
   endtask

   // receiver stall pattern with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 7) != 0);
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default plane z = 0
      send('{0, 0, 32'sh10000, 0, 0, -32'sh10000});      // clip start
      send('{0, 0, -32'sh10000, 32'sh30000, 0, 32'sh30000}); // clip end
      send('{1, 2, 0, 3, 4, 0});                         // both on plane
      send('{0, 0, 5, 0, 0, 9});                         // outside
      send('{0, 0, -5, 0, 0, -9});                       // inside
      send('{0, 0, 0, 0, 0, -7});                        // touching, inside
      send('{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000});
      send('{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
      idle(1);

      // extreme plane settings
      set_plane(16'h8000, 16'h7fff, 16'h4000, 32'h8000_0000);
      send('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
      send('{32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 5});
      idle(1);
      set_plane(16'hc000, 16'h0000, 16'hffff, 32'h7fff_ffff);
      send('{32'h8000_0000, 1, 2, 32'h7fff_ffff, 3, 4});
      send('{0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff});
      idle(1);

      // random phases over several planes
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) set_plane(16'h4000, 16'h0, 16'h0, 32'h0);
         else set_plane(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        (phase % 2) ? $urandom() :
                        32'($signed($urandom_range(0, 400000)) - 200000));
         random_burst(80);
      end

      // long receiver hold-off while segments keep coming
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         random_burst(100);
      join
      drain();
      random_burst(40);
      drain();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
